>>> sv/cbfl_pkg.sv
// Package for the chained block free-list store.
// Holds sizes, mode and status codes, and the controller/datapath command types.
// No dependencies.
package cbfl_pkg;

    localparam int NUM_BLOCKS = 64;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(NUM_BLOCKS);
    localparam int IDX_W      = 6;
    localparam int LINK_W     = 7;
    localparam int CNT_W      = 7;
    localparam int MODE_W     = 2;
    localparam int ST_W       = 2;

    localparam logic [LINK_W-1:0] LINK_END   = '1;
    localparam logic [CNT_W-1:0]  ACTIVE_MAX = CNT_W'(NUM_BLOCKS);

    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_NO_SPACE = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE    = 2'd2;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_FMT,
        OP_LATCH,
        OP_SINGLE,
        OP_WR_A,
        OP_WR_B,
        OP_WALK_START,
        OP_WALK_ACT,
        OP_WALK_CHK
    } t_op;

    typedef enum logic [1:0] {
        CLS_SINGLE,
        CLS_ALLOC,
        CLS_FREE,
        CLS_READ
    } t_cls;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        t_cls cls;
        logic can_emit;
        logic fmt_last;
        logic walk_stop;
        logic walk_emit;
    } t_stat;

endpackage

>>> sv/cbfl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read-first on a same-address write. No dependencies.
module cbfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> sv/cbfl_ctrl.sv
// Controller state machine of the chained block free-list store.
// Sequences format sweep, write words and chain walks; uses cbfl_pkg.
module cbfl_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_cfg_wr,
    input  cbfl_pkg::t_stat i_stat,
    output logic           o_in_ready,
    output cbfl_pkg::t_cmd o_cmd
);
    import cbfl_pkg::*;

    typedef enum logic [2:0] {
        S_FMT,
        S_IDLE,
        S_DISP,
        S_WR_B,
        S_WK_ACT,
        S_WK_CHK
    } t_state;

    t_state r_state, n_state;
    logic   r_in_ready, n_in_ready;
    t_op    op;

    always_comb begin
        n_state = r_state;
        op      = OP_NONE;
        unique case (r_state)
            S_FMT: begin
                op = OP_FMT;
                if (i_stat.fmt_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    op      = OP_LATCH;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                unique case (i_stat.cls)
                    CLS_SINGLE: begin
                        if (i_stat.can_emit) begin
                            op      = OP_SINGLE;
                            n_state = S_IDLE;
                        end
                    end
                    CLS_ALLOC: begin
                        op      = OP_WR_A;
                        n_state = S_WR_B;
                    end
                    default: begin
                        op      = OP_WALK_START;
                        n_state = S_WK_ACT;
                    end
                endcase
            end
            S_WR_B: begin
                if (i_stat.can_emit) begin
                    op      = OP_WR_B;
                    n_state = S_IDLE;
                end
            end
            S_WK_ACT: begin
                op      = OP_WALK_ACT;
                n_state = S_WK_CHK;
            end
            S_WK_CHK: begin
                if (!i_stat.walk_emit || i_stat.can_emit) begin
                    op      = OP_WALK_CHK;
                    n_state = i_stat.walk_stop ? S_IDLE : S_WK_ACT;
                end
            end
            default: begin
                n_state = S_FMT;
            end
        endcase
        if (i_cfg_wr) begin
            n_state = S_FMT;
        end
        n_in_ready = (n_state == S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_FMT;
            r_in_ready <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_ready <= n_in_ready;
        end
    end

    assign o_in_ready = r_in_ready;
    assign o_cmd.op   = op;
endmodule

>>> sv/cbfl_dpath.sv
// Datapath of the chained block free-list store: link and data RAMs,
// allocator registers and the output register. Uses cbfl_pkg and cbfl_ram.
module cbfl_dpath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  cbfl_pkg::t_cmd                   i_cmd,
    output cbfl_pkg::t_stat                  o_stat,
    input  logic                             i_cfg_wr,
    input  logic [cbfl_pkg::CNT_W-1:0]       i_cfg_active_blocks,
    input  logic [cbfl_pkg::MODE_W-1:0]      i_mode,
    input  logic [cbfl_pkg::DATA_WIDTH-1:0]  i_data_word,
    input  logic [cbfl_pkg::CNT_W-1:0]       i_record_blocks,
    input  logic                             i_first_word,
    input  logic                             i_last_word,
    input  logic [cbfl_pkg::IDX_W-1:0]       i_head_index,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic [cbfl_pkg::ST_W-1:0]        o_status,
    output logic [cbfl_pkg::IDX_W-1:0]       o_block_index,
    output logic [cbfl_pkg::IDX_W-1:0]       o_record_head,
    output logic [cbfl_pkg::DATA_WIDTH-1:0]  o_read_data,
    output logic [cbfl_pkg::CNT_W-1:0]       o_used_count,
    output logic                             o_last_result
);
    import cbfl_pkg::*;

    // allocator state
    logic [CNT_W-1:0]  r_active;
    logic [LINK_W-1:0] r_free_head;
    logic [CNT_W-1:0]  r_used;
    logic [LINK_W-1:0] r_prev;
    logic [IDX_W-1:0]  r_rec_head;
    logic              r_rejected;
    logic [ADDR_W-1:0] r_fmt_idx;
    logic              r_out_valid;

    // latched transaction and walk position
    logic [MODE_W-1:0]     r_mode;
    logic [DATA_WIDTH-1:0] r_data;
    logic [CNT_W-1:0]      r_need;
    logic                  r_first;
    logic                  r_last;
    logic [IDX_W-1:0]      r_head;
    logic [IDX_W-1:0]      r_cur;
    logic [CNT_W-1:0]      r_cnt;

    // output payload
    logic [ST_W-1:0]       r_status;
    logic [IDX_W-1:0]      r_block_index;
    logic [IDX_W-1:0]      r_record_head;
    logic [DATA_WIDTH-1:0] r_read_data;
    logic [CNT_W-1:0]      r_used_count;
    logic                  r_last_result;

    // RAM ports
    logic                  chain_we, chain_re, free_we, free_re, data_we, data_re;
    logic [ADDR_W-1:0]     chain_waddr, chain_raddr, free_waddr, free_raddr;
    logic [ADDR_W-1:0]     data_waddr, data_raddr;
    logic [LINK_W-1:0]     chain_wdata, chain_rdata, free_wdata, free_rdata;
    logic [DATA_WIDTH-1:0] data_wdata, data_rdata;

    // decode
    t_op               op;
    t_cls              cls;
    logic [CNT_W-1:0]  need_eff, free_cnt, used_inc, used_dec, cnt_next, cfg_sat;
    logic              no_space, no_block, head_bad, can_emit, fmt_last;
    logic              end_stop, cnt_stop, bad_link, walk_stop, walk_emit, walk_st2;
    logic [LINK_W-1:0] prev_eff, fmt_next;
    logic              prev_ok;
    logic [IDX_W-1:0]  blk_b;

    // result being loaded
    logic                  e_load;
    logic [ST_W-1:0]       e_status;
    logic [IDX_W-1:0]      e_block;
    logic [IDX_W-1:0]      e_rhead;
    logic [DATA_WIDTH-1:0] e_rdata;
    logic [CNT_W-1:0]      e_used;

    assign op = i_cmd.op;

    always_comb begin
        need_eff = (r_need == '0) ? CNT_W'(1) : r_need;
        free_cnt = (r_used < r_active) ? (r_active - r_used) : '0;
        no_space = r_first && (need_eff > free_cnt);
        no_block = (r_free_head >= r_active);
        head_bad = (CNT_W'(r_head) >= r_active);
        unique case (r_mode)
            MODE_WRITE: cls = (no_space || (!r_first && r_rejected) || no_block)
                              ? CLS_SINGLE : CLS_ALLOC;
            MODE_FREE:  cls = head_bad ? CLS_SINGLE : CLS_FREE;
            MODE_READ:  cls = head_bad ? CLS_SINGLE : CLS_READ;
            default:    cls = CLS_SINGLE;
        endcase

        can_emit = !r_out_valid || i_out_ready;
        fmt_last = (r_fmt_idx == ADDR_W'(NUM_BLOCKS - 1));
        fmt_next = ((LINK_W'(r_fmt_idx) + LINK_W'(1)) < r_active)
                   ? (LINK_W'(r_fmt_idx) + LINK_W'(1)) : LINK_END;

        cnt_next  = r_cnt + CNT_W'(1);
        cnt_stop  = (cnt_next >= r_active);
        end_stop  = (chain_rdata == LINK_END);
        bad_link  = (chain_rdata >= r_active);
        walk_stop = end_stop || cnt_stop || bad_link;
        walk_emit = (r_mode == MODE_READ) || walk_stop;
        // a free walk ends cleanly on the count limit before checking the link
        walk_st2  = (r_mode == MODE_READ) ? (!end_stop && bad_link)
                                          : (!end_stop && !cnt_stop && bad_link);

        prev_eff = r_first ? LINK_END : r_prev;
        prev_ok  = (prev_eff < r_active);
        blk_b    = r_free_head[IDX_W-1:0];
        used_inc = (r_used == '1) ? r_used : (r_used + CNT_W'(1));
        used_dec = (r_used == '0) ? r_used : (r_used - CNT_W'(1));

        if (i_cfg_active_blocks == '0) begin
            cfg_sat = CNT_W'(1);
        end else if (i_cfg_active_blocks > ACTIVE_MAX) begin
            cfg_sat = ACTIVE_MAX;
        end else begin
            cfg_sat = i_cfg_active_blocks;
        end
    end

    always_comb begin
        o_stat.cls       = cls;
        o_stat.can_emit  = can_emit;
        o_stat.fmt_last  = fmt_last;
        o_stat.walk_stop = walk_stop;
        o_stat.walk_emit = walk_emit;
    end

    // RAM port selection
    always_comb begin
        chain_we    = 1'b0;
        chain_waddr = r_fmt_idx;
        chain_wdata = LINK_END;
        chain_re    = 1'b0;
        chain_raddr = ADDR_W'(r_cur);
        free_we     = 1'b0;
        free_waddr  = r_fmt_idx;
        free_wdata  = fmt_next;
        free_re     = 1'b0;
        free_raddr  = ADDR_W'(blk_b);
        data_we     = 1'b0;
        data_waddr  = ADDR_W'(blk_b);
        data_wdata  = r_data;
        data_re     = 1'b0;
        data_raddr  = ADDR_W'(r_cur);
        unique case (op)
            OP_FMT: begin
                chain_we = 1'b1;
                free_we  = 1'b1;
            end
            OP_WR_A: begin
                data_we     = 1'b1;
                chain_we    = 1'b1;
                chain_waddr = ADDR_W'(blk_b);
                free_re     = 1'b1;
            end
            OP_WR_B: begin
                chain_we    = prev_ok;
                chain_waddr = ADDR_W'(prev_eff);
                chain_wdata = LINK_W'(blk_b);
                free_we     = 1'b1;
                free_waddr  = ADDR_W'(blk_b);
                free_wdata  = LINK_END;
            end
            OP_WALK_ACT: begin
                chain_re = 1'b1;
                if (r_mode == MODE_FREE) begin
                    chain_we    = 1'b1;
                    chain_waddr = ADDR_W'(r_cur);
                    free_we     = 1'b1;
                    free_waddr  = ADDR_W'(r_cur);
                    free_wdata  = r_free_head;
                end else begin
                    data_re = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // result selection
    always_comb begin
        e_load   = 1'b0;
        e_status = ST_OK;
        e_block  = '0;
        e_rhead  = '0;
        e_rdata  = '0;
        e_used   = r_used;
        unique case (op)
            OP_SINGLE: begin
                e_load = 1'b1;
                if (r_mode == MODE_WRITE) begin
                    e_status = ST_NO_SPACE;
                    e_rhead  = no_space ? '0 : r_rec_head;
                end else if (r_mode == MODE_FREE || r_mode == MODE_READ) begin
                    e_status = ST_RANGE;
                    e_block  = r_head;
                    e_rhead  = r_head;
                end else begin
                    e_status = ST_RANGE;
                end
            end
            OP_WR_B: begin
                e_load  = 1'b1;
                e_block = blk_b;
                e_rhead = prev_ok ? r_rec_head : blk_b;
                e_used  = used_inc;
            end
            OP_WALK_CHK: begin
                e_load   = walk_emit;
                e_status = walk_st2 ? ST_RANGE : ST_OK;
                e_block  = r_cur;
                e_rhead  = r_head;
                e_rdata  = (r_mode == MODE_READ) ? data_rdata : '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= ACTIVE_MAX;
            r_free_head <= '0;
            r_used      <= '0;
            r_prev      <= LINK_END;
            r_rec_head  <= '0;
            r_rejected  <= 1'b0;
            r_fmt_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (e_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_wr) begin
                r_active    <= cfg_sat;
                r_free_head <= '0;
                r_used      <= '0;
                r_prev      <= LINK_END;
                r_rec_head  <= '0;
                r_rejected  <= 1'b0;
                r_fmt_idx   <= '0;
            end else begin
                unique case (op)
                    OP_FMT: begin
                        r_fmt_idx <= r_fmt_idx + ADDR_W'(1);
                    end
                    OP_SINGLE: begin
                        if (r_mode == MODE_WRITE) begin
                            if (r_first) begin
                                r_prev     <= LINK_END;
                                r_rejected <= no_space && !r_last;
                            end else if (r_rejected && r_last) begin
                                r_rejected <= 1'b0;
                            end
                        end
                    end
                    OP_WR_B: begin
                        r_free_head <= free_rdata;
                        if (!prev_ok) begin
                            r_rec_head <= blk_b;
                        end
                        r_used     <= used_inc;
                        r_prev     <= r_last ? LINK_END : LINK_W'(blk_b);
                        r_rejected <= 1'b0;
                    end
                    OP_WALK_ACT: begin
                        if (r_mode == MODE_FREE) begin
                            r_free_head <= LINK_W'(r_cur);
                            r_used      <= used_dec;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (op == OP_LATCH) begin
            r_mode  <= i_mode;
            r_data  <= i_data_word;
            r_need  <= i_record_blocks;
            r_first <= i_first_word;
            r_last  <= i_last_word;
            r_head  <= i_head_index;
        end
        if (op == OP_WALK_START) begin
            r_cur <= r_head;
            r_cnt <= '0;
        end else if (op == OP_WALK_CHK && !walk_stop) begin
            r_cur <= chain_rdata[IDX_W-1:0];
            r_cnt <= cnt_next;
        end
        if (e_load) begin
            r_status      <= e_status;
            r_block_index <= e_block;
            r_record_head <= e_rhead;
            r_read_data   <= e_rdata;
            r_used_count  <= e_used;
            r_last_result <= (op == OP_WALK_CHK) ? walk_stop : 1'b1;
        end
    end

    cbfl_ram #(.WIDTH(LINK_W), .DEPTH(NUM_BLOCKS)) u_chain_ram (
        .i_clk   (i_clk),
        .i_we    (chain_we),
        .i_waddr (chain_waddr),
        .i_wdata (chain_wdata),
        .i_re    (chain_re),
        .i_raddr (chain_raddr),
        .o_rdata (chain_rdata)
    );

    cbfl_ram #(.WIDTH(LINK_W), .DEPTH(NUM_BLOCKS)) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (free_we),
        .i_waddr (free_waddr),
        .i_wdata (free_wdata),
        .i_re    (free_re),
        .i_raddr (free_raddr),
        .o_rdata (free_rdata)
    );

    cbfl_ram #(.WIDTH(DATA_WIDTH), .DEPTH(NUM_BLOCKS)) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (data_we),
        .i_waddr (data_waddr),
        .i_wdata (data_wdata),
        .i_re    (data_re),
        .i_raddr (data_raddr),
        .o_rdata (data_rdata)
    );

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_block_index = r_block_index;
    assign o_record_head = r_record_head;
    assign o_read_data   = r_read_data;
    assign o_used_count  = r_used_count;
    assign o_last_result = r_last_result;
endmodule

>>> sv/chained_block_free_list_store.sv
// Top level of the chained block free-list store.
// Instantiates cbfl_ctrl and cbfl_dpath; uses cbfl_pkg.
//
// Usage:
//  Input channel (i_in_valid/o_in_ready) takes one transaction per command:
//  write a record word, free a chain, or read a chain. Output channel
//  (o_out_valid/i_out_ready) returns result transactions; o_last_result marks
//  the final result of a command. Config channel (i_cfg_valid/o_cfg_ready)
//  sets active_blocks and reformats the store; it is always ready.
//  Flow: one command is in flight at a time. A write word is latched, then
//  writes the data and link RAMs, then the previous link and the free list
//  while its result is registered; a command that fails its checks is latched
//  and then emits its result. A free or read walk has a start state, then a
//  link RAM read state and a decision state per block. A read emits one result
//  per block. Reset and every config write start a format sweep over all
//  NUM_BLOCKS (64) link RAM entries; o_in_ready stays low until it is done.
//  If the receiver stalls, the result waits in the output register and the
//  walk holds on the next result; accepted input is never dropped.
module chained_block_free_list_store (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [cbfl_pkg::MODE_W-1:0]      i_mode,
    input  logic [cbfl_pkg::DATA_WIDTH-1:0]  i_data_word,
    input  logic [cbfl_pkg::CNT_W-1:0]       i_record_blocks,
    input  logic                             i_first_word,
    input  logic                             i_last_word,
    input  logic [cbfl_pkg::IDX_W-1:0]       i_head_index,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [cbfl_pkg::ST_W-1:0]        o_status,
    output logic [cbfl_pkg::IDX_W-1:0]       o_block_index,
    output logic [cbfl_pkg::IDX_W-1:0]       o_record_head,
    output logic [cbfl_pkg::DATA_WIDTH-1:0]  o_read_data,
    output logic [cbfl_pkg::CNT_W-1:0]       o_used_count,
    output logic                             o_last_result,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [cbfl_pkg::CNT_W-1:0]       i_cfg_active_blocks
);
    import cbfl_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    cbfl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cfg_wr   (cfg_wr),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    cbfl_dpath u_dpath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_stat              (stat),
        .i_cfg_wr            (cfg_wr),
        .i_cfg_active_blocks (i_cfg_active_blocks),
        .i_mode              (i_mode),
        .i_data_word         (i_data_word),
        .i_record_blocks     (i_record_blocks),
        .i_first_word        (i_first_word),
        .i_last_word         (i_last_word),
        .i_head_index        (i_head_index),
        .i_out_ready         (i_out_ready),
        .o_out_valid         (o_out_valid),
        .o_status            (o_status),
        .o_block_index       (o_block_index),
        .o_record_head       (o_record_head),
        .o_read_data         (o_read_data),
        .o_used_count        (o_used_count),
        .o_last_result       (o_last_result)
    );

    // one command in flight at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted back to back");

    // a config write starts the format sweep
    a_cfg_formats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> !o_in_ready)
        else $error("ready high right after config write");

    // a range error always ends the command
    a_range_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_RANGE) |-> o_last_result)
        else $error("range error result not final");

    // a no-space result is final and names no block
    a_nospace_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_NO_SPACE) |-> (o_last_result && o_block_index == '0))
        else $error("bad no-space result");
endmodule
